// ===== rtl/wat_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wat_pkg: shared types and constants for the window average trend classifier
// Widths, register indexes, direction codes, controller state and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package wat_pkg;

   localparam int MAX_WINDOW = 16;
   localparam int RING_DEPTH = 2 * MAX_WINDOW;
   localparam int PTR_W      = $clog2(RING_DEPTH);
   localparam int HELD_W     = $clog2(RING_DEPTH + 1);
   localparam int COUNT_W    = $clog2(MAX_WINDOW + 1);
   localparam int SAMPLE_W   = 15;
   localparam int THRESH_W   = 15;
   localparam int WSIZE_W    = 5;
   localparam int CSR_DATA_W = 15;
   localparam int CSR_IDX_W  = 1;
   localparam int DIFF_W     = 16;
   localparam int DIR_W      = 2;
   localparam int SUM_W      = SAMPLE_W + COUNT_W;
   localparam int DIV_CNT_W  = $clog2(SUM_W);

   localparam logic [WSIZE_W-1:0]  WSIZE_RESET  = WSIZE_W'(5);
   localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(512);

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SIZE      = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEADY_THRESHOLD = 1'b1;

   localparam logic [DIR_W-1:0] DIR_NOT_ENOUGH = 2'd0;
   localparam logic [DIR_W-1:0] DIR_STEADY     = 2'd1;
   localparam logic [DIR_W-1:0] DIR_IMPROVING  = 2'd2;
   localparam logic [DIR_W-1:0] DIR_DECLINING  = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_DRAIN,
      ST_DIVR_GO,
      ST_DIVR_WAIT,
      ST_DIVP_GO,
      ST_DIVP_WAIT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic accept;
      logic read_step;
      logic div_go;
      logic div_prev;
      logic cap_recent;
      logic cap_prev;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic skip;
      logic last_issue;
      logic div_done;
      logic out_free;
   } status_type;

endpackage

// ===== rtl/wat_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wat_req_if: sample channel
// Valid/ready channel carrying one score sample per word.
// ----------------------------------------------------------------------------
interface wat_req_if;
   logic                         valid;
   logic                         ready;
   logic [wat_pkg::SAMPLE_W-1:0] score_sample;

   modport source (output valid, output score_sample, input ready);
   modport sink   (input valid, input score_sample, output ready);
endinterface

// ===== rtl/wat_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wat_rsp_if: trend result channel
// Valid/ready channel carrying one classification word per sample.
// ----------------------------------------------------------------------------
interface wat_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [wat_pkg::DIR_W-1:0]         direction;
   logic [wat_pkg::COUNT_W-1:0]       recent_count;
   logic [wat_pkg::COUNT_W-1:0]       previous_count;
   logic signed [wat_pkg::DIFF_W-1:0] mean_difference;

   modport source (output valid, output direction, output recent_count,
                   output previous_count, output mean_difference, input ready);
   modport sink   (input valid, input direction, input recent_count,
                   input previous_count, input mean_difference, output ready);
endinterface

// ===== rtl/window_average_trend_classifier.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_average_trend_classifier: windowed mean trend classifier
// Flow: after its sample word is taken, the ring is walked one entry per
//   cycle over N = recent + previous count entries (at most 32), the last
//   read drains, two serial divisions run in turn on the shared divider
//   and the result word is loaded once the output register is free; with
//   too little data the walk and the divisions are skipped.
// Overlap: the next sample word is taken only once the last word is
//   loaded, while that word may still wait in the output register.
// Reset: synchronous, clears pointer, sample count and registers to defaults.
// ----------------------------------------------------------------------------
module window_average_trend_classifier (
   input  logic                             clock,
   input  logic                             reset,
   wat_req_if.sink                          req_ch,
   wat_rsp_if.source                        rsp_ch,
   input  logic                             csr_write_enable,
   input  logic [wat_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [wat_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   wat_pkg::cmd_type    cmd;
   wat_pkg::status_type status;

   wat_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   wat_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_sample          (req_ch.score_sample),
      .rsp_ready           (rsp_ch.ready),
      .rsp_valid           (rsp_ch.valid),
      .rsp_direction       (rsp_ch.direction),
      .rsp_recent_count    (rsp_ch.recent_count),
      .rsp_previous_count  (rsp_ch.previous_count),
      .rsp_mean_difference (rsp_ch.mean_difference),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

endmodule

// ===== rtl/wat_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wat_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module wat_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/wat_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wat_div: serial restoring divider
// Divides a window sum by a sample count, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wat_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [wat_pkg::SUM_W-1:0]    dividend,
   input  logic [wat_pkg::COUNT_W-1:0]  divisor,
   output logic                         done,
   output logic [wat_pkg::SAMPLE_W-1:0] quotient
);

   logic [wat_pkg::SUM_W-1:0]     quo_ff, quo_in;
   logic [wat_pkg::COUNT_W-1:0]   rem_ff, rem_in;
   logic [wat_pkg::COUNT_W-1:0]   dsr_ff, dsr_in;
   logic [wat_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [wat_pkg::COUNT_W:0]     trial;
   logic                          qbit;

   always_comb begin
      trial  = {rem_ff, quo_ff[wat_pkg::SUM_W-1]};
      qbit   = (trial >= {1'b0, dsr_ff});
      quo_in = quo_ff;
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract when it fits
         rem_in = qbit ? wat_pkg::COUNT_W'(trial - {1'b0, dsr_ff})
                       : trial[wat_pkg::COUNT_W-1:0];
         quo_in = {quo_ff[wat_pkg::SUM_W-2:0], qbit};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == wat_pkg::DIV_CNT_W'(wat_pkg::SUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff[wat_pkg::SAMPLE_W-1:0];

endmodule

// ===== rtl/wat_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wat_datapath: history ring, window sums, means and classification
// Holds the configuration registers, ring pointer and sample count, walks
// the ring to sum both windows, divides and registers the result word.
// ----------------------------------------------------------------------------
module wat_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  wat_pkg::cmd_type                    cmd,
   output wat_pkg::status_type                 status,
   input  logic [wat_pkg::SAMPLE_W-1:0]        req_sample,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic [wat_pkg::DIR_W-1:0]           rsp_direction,
   output logic [wat_pkg::COUNT_W-1:0]         rsp_recent_count,
   output logic [wat_pkg::COUNT_W-1:0]         rsp_previous_count,
   output logic signed [wat_pkg::DIFF_W-1:0]   rsp_mean_difference,
   input  logic                                csr_write_enable,
   input  logic [wat_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [wat_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   logic [wat_pkg::WSIZE_W-1:0]  window_ff;
   logic [wat_pkg::THRESH_W-1:0] thresh_ff;
   logic [wat_pkg::PTR_W-1:0]    wp_ff;
   logic [wat_pkg::HELD_W-1:0]   held_ff;
   logic [wat_pkg::COUNT_W-1:0]  rc_ff, pc_ff;
   logic                         skip_ff;
   logic [wat_pkg::HELD_W-1:0]   k_ff;
   logic                         tag_valid_ff, tag_recent_ff;
   logic [wat_pkg::SUM_W-1:0]    sum_r_ff, sum_p_ff;
   logic [wat_pkg::SAMPLE_W-1:0] mean_r_ff, mean_p_ff;

   logic                              out_valid_ff;
   logic [wat_pkg::DIR_W-1:0]         out_dir_ff;
   logic [wat_pkg::COUNT_W-1:0]       out_rc_ff, out_pc_ff;
   logic signed [wat_pkg::DIFF_W-1:0] out_diff_ff;

   logic [wat_pkg::HELD_W-1:0]   held_in, held_m1, remaining;
   logic [wat_pkg::COUNT_W-1:0]  w_sat, rc_in, pc_in;
   logic                         skip_in;
   logic [wat_pkg::PTR_W-1:0]    rd_addr;
   logic [wat_pkg::SAMPLE_W-1:0] rd_data;
   logic [wat_pkg::HELD_W-1:0]   last_k;
   logic                         div_done;
   logic [wat_pkg::SAMPLE_W-1:0] div_quo;
   logic signed [wat_pkg::DIFF_W-1:0] diff;
   logic signed [wat_pkg::DIFF_W:0]   diff_x, thr_x;
   logic [wat_pkg::DIR_W-1:0]    dir;

   // window counts for the sample being taken
   always_comb begin
      held_in = (held_ff < wat_pkg::HELD_W'(wat_pkg::RING_DEPTH)) ? held_ff + 1'b1 : held_ff;
      w_sat   = (window_ff > wat_pkg::WSIZE_W'(wat_pkg::MAX_WINDOW))
              ? wat_pkg::COUNT_W'(wat_pkg::MAX_WINDOW) : wat_pkg::COUNT_W'(window_ff);
      held_m1 = held_in - 1'b1;
      rc_in   = (wat_pkg::HELD_W'(w_sat) < held_m1) ? w_sat : held_m1[wat_pkg::COUNT_W-1:0];
      remaining = held_in - wat_pkg::HELD_W'(rc_in);
      pc_in   = (wat_pkg::HELD_W'(w_sat) < remaining) ? w_sat
              : remaining[wat_pkg::COUNT_W-1:0];
      skip_in = (held_in < wat_pkg::HELD_W'(2)) || (w_sat == '0);
   end

   assign last_k  = wat_pkg::HELD_W'(rc_ff) + wat_pkg::HELD_W'(pc_ff) - 1'b1;
   assign rd_addr = wp_ff - wat_pkg::PTR_W'(1) - k_ff[wat_pkg::PTR_W-1:0];

   wat_ram #(
      .WIDTH (wat_pkg::SAMPLE_W),
      .DEPTH (wat_pkg::RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (cmd.accept),
      .wr_addr (wp_ff),
      .wr_data (req_sample),
      .rd_en   (cmd.read_step),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   wat_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_go),
      .dividend (cmd.div_prev ? sum_p_ff : sum_r_ff),
      .divisor  (cmd.div_prev ? pc_ff : rc_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   // difference and dead band
   always_comb begin
      diff   = wat_pkg::DIFF_W'({1'b0, mean_r_ff}) - wat_pkg::DIFF_W'({1'b0, mean_p_ff});
      diff_x = {diff[wat_pkg::DIFF_W-1], diff};
      thr_x  = $signed({2'b00, thresh_ff});
      if (diff_x > thr_x) begin
         dir = wat_pkg::DIR_IMPROVING;
      end else if (diff_x < -thr_x) begin
         dir = wat_pkg::DIR_DECLINING;
      end else begin
         dir = wat_pkg::DIR_STEADY;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= wat_pkg::WSIZE_RESET;
         thresh_ff    <= wat_pkg::THRESH_RESET;
         wp_ff        <= '0;
         held_ff      <= '0;
         tag_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               wat_pkg::CSR_WINDOW_SIZE: begin
                  window_ff <= csr_write_data[wat_pkg::WSIZE_W-1:0];
               end
               wat_pkg::CSR_STEADY_THRESHOLD: begin
                  thresh_ff <= csr_write_data[wat_pkg::THRESH_W-1:0];
               end
               default: begin
               end
            endcase
         end
         if (cmd.accept) begin
            wp_ff   <= wp_ff + 1'b1;
            held_ff <= held_in;
         end
         tag_valid_ff <= cmd.read_step;
         if (cmd.load_out) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         rc_ff    <= rc_in;
         pc_ff    <= pc_in;
         skip_ff  <= skip_in;
         k_ff     <= '0;
         sum_r_ff <= '0;
         sum_p_ff <= '0;
      end else begin
         if (cmd.read_step) begin
            k_ff <= k_ff + 1'b1;
         end
         if (tag_valid_ff) begin
            if (tag_recent_ff) begin
               sum_r_ff <= sum_r_ff + wat_pkg::SUM_W'(rd_data);
            end else begin
               sum_p_ff <= sum_p_ff + wat_pkg::SUM_W'(rd_data);
            end
         end
      end
      tag_recent_ff <= (k_ff < wat_pkg::HELD_W'(rc_ff));
      if (cmd.cap_recent) begin
         mean_r_ff <= div_quo;
      end
      if (cmd.cap_prev) begin
         mean_p_ff <= div_quo;
      end
      if (cmd.load_out) begin
         out_dir_ff  <= skip_ff ? wat_pkg::DIR_NOT_ENOUGH : dir;
         out_rc_ff   <= skip_ff ? '0 : rc_ff;
         out_pc_ff   <= skip_ff ? '0 : pc_ff;
         out_diff_ff <= skip_ff ? '0 : diff;
      end
   end

   assign status.skip       = skip_ff;
   assign status.last_issue = (k_ff == last_k);
   assign status.div_done   = div_done;
   assign status.out_free   = !out_valid_ff || rsp_ready;

   assign rsp_valid           = out_valid_ff;
   assign rsp_direction       = out_dir_ff;
   assign rsp_recent_count    = out_rc_ff;
   assign rsp_previous_count  = out_pc_ff;
   assign rsp_mean_difference = out_diff_ff;

endmodule

// ===== rtl/wat_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wat_ctrl: sequencing controller
// Takes a sample, walks both windows and runs the two divisions in turn
// (skipped on too little data), then loads the result once output is free.
// ----------------------------------------------------------------------------
module wat_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  wat_pkg::status_type status,
   output wat_pkg::cmd_type    cmd
);

   wat_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wat_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         wat_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = wat_pkg::ST_SUM;
            end
         end
         wat_pkg::ST_SUM: begin
            if (status.skip) begin
               state_in = wat_pkg::ST_OUT;
            end else begin
               cmd.read_step = 1'b1;
               if (status.last_issue) begin
                  state_in = wat_pkg::ST_DRAIN;
               end
            end
         end
         wat_pkg::ST_DRAIN: begin
            state_in = wat_pkg::ST_DIVR_GO;
         end
         wat_pkg::ST_DIVR_GO: begin
            cmd.div_go = 1'b1;
            state_in   = wat_pkg::ST_DIVR_WAIT;
         end
         wat_pkg::ST_DIVR_WAIT: begin
            if (status.div_done) begin
               cmd.cap_recent = 1'b1;
               state_in       = wat_pkg::ST_DIVP_GO;
            end
         end
         wat_pkg::ST_DIVP_GO: begin
            cmd.div_go   = 1'b1;
            cmd.div_prev = 1'b1;
            state_in     = wat_pkg::ST_DIVP_WAIT;
         end
         wat_pkg::ST_DIVP_WAIT: begin
            if (status.div_done) begin
               cmd.cap_prev = 1'b1;
               state_in     = wat_pkg::ST_OUT;
            end
         end
         wat_pkg::ST_OUT: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = wat_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wat_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the window average trend classifier
// Streams score samples over the valid/ready sample channel, predicts each
// trend word from a private copy of the sample history and the registers,
// and checks every returned word field by field. Covers directed corner
// cases, then random trend phases under several register settings with
// random stalls on both channels and one long stall of the result side.
// ----------------------------------------------------------------------------
module tb_top;
   import wat_pkg::*;

   typedef struct packed {
      logic [DIR_W-1:0]         direction;
      logic [COUNT_W-1:0]       recent_count;
      logic [COUNT_W-1:0]       previous_count;
      logic signed [DIFF_W-1:0] mean_difference;
   } trend_word_type;

   class trend_tracker;
      logic [SAMPLE_W-1:0] history [RING_DEPTH];
      logic [PTR_W-1:0]    next_slot = '0;
      int                  held = 0;
      int                  window_size = 5;
      int                  dead_band = 512;
      int                  failures = 0;
      trend_word_type      pending_trends[$];

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         if (idx == CSR_WINDOW_SIZE) begin
            window_size = int'(value[WSIZE_W-1:0]);
         end else begin
            dead_band = int'(value[THRESH_W-1:0]);
         end
      endfunction

      function void take_sample(logic [SAMPLE_W-1:0] sample);
         trend_word_type   word;
         int               w;
         int               recent_n;
         int               prev_n;
         int               recent_sum;
         int               prev_sum;
         int               diff;
         logic [PTR_W-1:0] slot;
         history[next_slot] = sample;
         next_slot++;
         if (held < RING_DEPTH) held++;
         word = '0;
         word.direction = DIR_NOT_ENOUGH;
         w = (window_size > MAX_WINDOW) ? MAX_WINDOW : window_size;
         if (held >= 2 && w != 0) begin
            recent_n = (w < held - 1) ? w : held - 1;
            prev_n = (w < held - recent_n) ? w : held - recent_n;
            recent_sum = 0;
            prev_sum = 0;
            slot = next_slot;
            for (int k = 0; k < recent_n; k++) begin
               slot--;
               recent_sum += int'(history[slot]);
            end
            for (int k = 0; k < prev_n; k++) begin
               slot--;
               prev_sum += int'(history[slot]);
            end
            diff = recent_sum / recent_n - prev_sum / prev_n;
            if (diff > dead_band) begin
               word.direction = DIR_IMPROVING;
            end else if (diff < -dead_band) begin
               word.direction = DIR_DECLINING;
            end else begin
               word.direction = DIR_STEADY;
            end
            word.recent_count = COUNT_W'(recent_n);
            word.previous_count = COUNT_W'(prev_n);
            word.mean_difference = DIFF_W'(diff);
         end
         pending_trends.push_back(word);
      endfunction

      function void match_word(trend_word_type got);
         trend_word_type want;
         if (pending_trends.size() == 0) begin
            $error("unexpected result word");
            failures++;
            return;
         end
         want = pending_trends.pop_front();
         if (got.direction !== want.direction) begin
            $error("direction: expected %0d, actual %0d", want.direction, got.direction);
            failures++;
         end
         if (got.recent_count !== want.recent_count) begin
            $error("recent_count: expected %0d, actual %0d",
                   want.recent_count, got.recent_count);
            failures++;
         end
         if (got.previous_count !== want.previous_count) begin
            $error("previous_count: expected %0d, actual %0d",
                   want.previous_count, got.previous_count);
            failures++;
         end
         if (got.mean_difference !== want.mean_difference) begin
            $error("mean_difference: expected %0d, actual %0d",
                   want.mean_difference, got.mean_difference);
            failures++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;
   bit                    gaps_on = 1'b1;
   int                    words_taken = 0;
   int                    hold_left = 0;
   bit                    hold_done = 1'b0;
   trend_tracker          tracker = new();

   wat_req_if req_ch ();
   wat_rsp_if rsp_ch ();

   window_average_trend_classifier DUT (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   task automatic send_sample(input logic [SAMPLE_W-1:0] sample);
      if (gaps_on && $urandom_range(0, 99) < 22) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < 22);
      end
      req_ch.valid <= 1'b1;
      req_ch.score_sample <= sample;
      do @(posedge clock); while (!req_ch.ready);
      tracker.take_sample(sample);
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (tracker.pending_trends.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_settings(input int wsize, input int band);
      logic [CSR_DATA_W-1:0] wdata;
      logic [CSR_DATA_W-1:0] bdata;
      wdata = {(CSR_DATA_W-WSIZE_W)'($urandom_range(0, 1023)), WSIZE_W'(wsize)};
      bdata = CSR_DATA_W'(band);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_WINDOW_SIZE;
      csr_write_data <= wdata;
      tracker.set_register(CSR_WINDOW_SIZE, wdata);
      @(posedge clock);
      csr_index <= CSR_STEADY_THRESHOLD;
      csr_write_data <= bdata;
      tracker.set_register(CSR_STEADY_THRESHOLD, bdata);
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // result side: check, then pick ready for the next cycle
   initial begin
      trend_word_type seen;
      rsp_ch.ready <= 1'b0;
      wait (reset == 1'b0);
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen.direction = rsp_ch.direction;
            seen.recent_count = rsp_ch.recent_count;
            seen.previous_count = rsp_ch.previous_count;
            seen.mean_difference = rsp_ch.mean_difference;
            tracker.match_word(seen);
            words_taken++;
         end
         if (words_taken == 230 && !hold_done) begin
            hold_left = 400;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (gaps_on && $urandom_range(0, 99) < 22) begin
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin
      int window_plan[8];
      int band_plan[8];
      int wsz;
      int band;
      int base;
      int bias;
      int r;
      logic [SAMPLE_W-1:0] sample;
      window_plan = '{1, 16, 3, 31, 8, 2, 0, 12};
      band_plan = '{0, 25600, 100, 32767, 512, 1, 768, 2048};
      req_ch.valid <= 1'b0;
      req_ch.score_sample <= '0;
      csr_write_enable <= 1'b0;
      csr_index <= CSR_WINDOW_SIZE;
      csr_write_data <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: first word lacks data, then extremes and over-range
      send_sample(15'd0);
      send_sample(15'd0);
      send_sample(15'd25600);
      send_sample(15'd32767);
      send_sample(15'd0);
      send_sample(15'd32767);
      drain_results();

      // single-sample windows: differences on and just past the dead band
      program_settings(1, 512);
      send_sample(15'd10000);
      send_sample(15'd10512);
      send_sample(15'd11025);
      send_sample(15'd10513);
      send_sample(15'd10000);
      drain_results();

      program_settings(0, 32767);
      send_sample(15'd5);
      send_sample(15'd25600);
      drain_results();

      program_settings(31, 0);
      send_sample(15'd100);
      send_sample(15'd100);
      send_sample(15'd101);
      send_sample(15'd32767);
      drain_results();

      program_settings(16, 25600);
      send_sample(15'd0);
      send_sample(15'd25600);
      send_sample(15'd32767);
      drain_results();

      for (int p = 0; p < 12; p++) begin
         if (p < 8) begin
            wsz = window_plan[p];
            band = band_plan[p];
         end else begin
            wsz = ($urandom_range(0, 9) == 0) ? int'($urandom_range(17, 31))
                                               : int'($urandom_range(1, 16));
            band = int'($urandom_range(0, 1500));
         end
         program_settings(wsz, band);
         gaps_on = (p != 3);
         base = int'($urandom_range(0, 25600));
         bias = int'($urandom_range(0, 400)) - 200;
         for (int n = 0; n < 50; n++) begin
            r = int'($urandom_range(0, 99));
            if (r < 8) begin
               sample = SAMPLE_W'($urandom_range(0, 32767));
            end else if (r < 14) begin
               sample = (r % 2 == 0) ? SAMPLE_W'(0) : SAMPLE_W'(25600);
            end else begin
               if ($urandom_range(0, 19) == 0) bias = -bias;
               base = base + bias + int'($urandom_range(0, 400)) - 200;
               if (base < 0) base = 0;
               if (base > 25600) base = 25600;
               sample = SAMPLE_W'(base);
            end
            send_sample(sample);
         end
         drain_results();
      end

      gaps_on = 1'b1;
      repeat (150) @(posedge clock);
      if (tracker.failures == 0 && tracker.pending_trends.size() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("tb_top: FAIL");
      $finish;
   end

endmodule
